/* hw/rtl/cctlv_pkg.sv */
// shared types and constants for the capability container tlv parser
// no dependencies
package cctlv_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned STATUS_W = 3;

	localparam logic [BYTE_W-1:0] CTRL_TLV_TYPE = 8'h04;
	localparam logic [BYTE_W-1:0] CTRL_TLV_LEN = 8'd6;
	localparam logic [WORD_W-1:0] MIN_CC_LEN = 16'd15;
	localparam logic [WORD_W-1:0] WALK_START = 16'd7;

	// header byte positions
	localparam logic [WORD_W-1:0] POS_LEN_HI = 16'd0;
	localparam logic [WORD_W-1:0] POS_LEN_LO = 16'd1;
	localparam logic [WORD_W-1:0] POS_READ_HI = 16'd3;
	localparam logic [WORD_W-1:0] POS_READ_LO = 16'd4;
	localparam logic [WORD_W-1:0] POS_MAX = 16'hFFFF;

	// control tlv value byte indexes
	localparam logic [2:0] VAL_ID_HI = 3'd0;
	localparam logic [2:0] VAL_ID_LO = 3'd1;
	localparam logic [2:0] VAL_SIZE_HI = 3'd2;
	localparam logic [2:0] VAL_SIZE_LO = 3'd3;
	localparam logic [2:0] VAL_ACCESS = 3'd5;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LENGTH = 3'd2,
		PH_SKIP   = 3'd3,
		PH_VALUE  = 3'd4
	} walk_phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_SHORT    = 3'd1,
		ST_BADLEN   = 3'd2,
		ST_OVERRUN  = 3'd3,
		ST_BADCTRL  = 3'd4,
		ST_NOTFOUND = 3'd5
	} cc_status_t;

	typedef struct packed {
		cc_status_t         status;
		logic [WORD_W-1:0]  file_ident;
		logic [WORD_W-1:0]  max_file_size;
		logic [WORD_W-1:0]  read_len_max;
		logic [BYTE_W-1:0]  wr_access;
	} cc_result_t;

endpackage

/* hw/rtl/capability_container_tlv_parser_unit.sv */
// a last byte is registered in the input stage when it is accepted, and its result is registered
// in the result stage when that byte steps on, which a result still held can delay
// throughput: one byte per cycle; a last byte waits in the input register while the
// previous result is still held, and that stall reaches in_ready
// reset: arst_n clears the input stage, the result stage and all parser state;
// each result also returns the parser to its reset state for the next container
module capability_container_tlv_parser_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [cctlv_pkg::BYTE_W-1:0]     cc_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cctlv_pkg::STATUS_W-1:0]   status,
	output logic [cctlv_pkg::WORD_W-1:0]     file_ident,
	output logic [cctlv_pkg::WORD_W-1:0]     max_file_size,
	output logic [cctlv_pkg::WORD_W-1:0]     read_len_max,
	output logic [cctlv_pkg::BYTE_W-1:0]     wr_access
);

	logic                         valid_s1;
	logic [cctlv_pkg::BYTE_W-1:0] byte_s1;
	logic                         last_s1;
	logic                         step;
	cctlv_pkg::cc_result_t        res;
	logic                         out_valid_q;
	cctlv_pkg::cc_result_t        res_q;

	// a byte without the mark never waits on the result stage
	assign step = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= cc_byte;
			last_s1 <= last_byte;
		end
	end

	cctlv_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cc_byte   (byte_s1),
		.last_byte (last_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign file_ident = res_q.file_ident;
	assign max_file_size = res_q.max_file_size;
	assign read_len_max = res_q.read_len_max;
	assign wr_access = res_q.wr_access;

endmodule

/* hw/rtl/cctlv_walk.sv */
// container state and per-byte update: header fields, tlv walk, final verdict
// depends on cctlv_pkg
module cctlv_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [cctlv_pkg::BYTE_W-1:0]   cc_byte,
	input  logic                           last_byte,
	output cctlv_pkg::cc_result_t          result
);

	logic [cctlv_pkg::WORD_W-1:0] pos_q, pos_n;
	logic [cctlv_pkg::WORD_W-1:0] dl_q, dl_n;
	logic [cctlv_pkg::WORD_W-1:0] rl_q, rl_n;
	cctlv_pkg::walk_phase_t       phase_q, phase_n;
	logic [cctlv_pkg::BYTE_W-1:0] type_q, type_n;
	logic [cctlv_pkg::BYTE_W-1:0] left_q, left_n;
	logic [2:0]                   vi_q, vi_n;
	logic [cctlv_pkg::WORD_W-1:0] fid_q, fid_n;
	logic [cctlv_pkg::WORD_W-1:0] fsize_q, fsize_n;
	logic [cctlv_pkg::BYTE_W-1:0] acc_q, acc_n;
	cctlv_pkg::cc_status_t        verdict_q, verdict_n;
	logic                         dec_q, dec_n;

	logic [cctlv_pkg::WORD_W:0]   count;
	logic [cctlv_pkg::WORD_W:0]   tlv_end;
	logic                         walk_on;
	cctlv_pkg::cc_status_t        st;

	always_comb begin
		dl_n = dl_q;
		rl_n = rl_q;
		phase_n = phase_q;
		type_n = type_q;
		left_n = left_q;
		vi_n = vi_q;
		fid_n = fid_q;
		fsize_n = fsize_q;
		acc_n = acc_q;
		verdict_n = verdict_q;
		dec_n = dec_q;

		case (pos_q)
			cctlv_pkg::POS_LEN_HI: dl_n = {cc_byte, 8'h00};
			cctlv_pkg::POS_LEN_LO: dl_n = {dl_q[15:8], cc_byte};
			cctlv_pkg::POS_READ_HI: rl_n = {cc_byte, 8'h00};
			cctlv_pkg::POS_READ_LO: rl_n = {rl_q[15:8], cc_byte};
			default: ;
		endcase

		count = {1'b0, pos_q} + 17'd1;
		tlv_end = count + {9'd0, cc_byte};
		walk_on = !dec_q && (phase_q != cctlv_pkg::PH_HEADER) && (pos_q < dl_n);

		if (walk_on) begin
			case (phase_q)
				cctlv_pkg::PH_TYPE: begin
					// type byte needs room for its length byte too
					if (count < {1'b0, dl_n} && cc_byte != 8'h00) begin
						type_n = cc_byte;
						phase_n = cctlv_pkg::PH_LENGTH;
					end
				end
				cctlv_pkg::PH_LENGTH: begin
					if (tlv_end > {1'b0, dl_n}) begin
						verdict_n = cctlv_pkg::ST_OVERRUN;
						dec_n = 1'b1;
					end else if (type_q == cctlv_pkg::CTRL_TLV_TYPE) begin
						if (cc_byte != cctlv_pkg::CTRL_TLV_LEN) begin
							verdict_n = cctlv_pkg::ST_BADCTRL;
							dec_n = 1'b1;
						end else begin
							vi_n = 3'd0;
							phase_n = cctlv_pkg::PH_VALUE;
						end
					end else if (cc_byte == 8'h00) begin
						phase_n = cctlv_pkg::PH_TYPE;
					end else begin
						left_n = cc_byte;
						phase_n = cctlv_pkg::PH_SKIP;
					end
				end
				cctlv_pkg::PH_SKIP: begin
					left_n = left_q - 8'd1;
					if (left_q == 8'd1)
						phase_n = cctlv_pkg::PH_TYPE;
				end
				cctlv_pkg::PH_VALUE: begin
					case (vi_q)
						cctlv_pkg::VAL_ID_HI: fid_n = {cc_byte, 8'h00};
						cctlv_pkg::VAL_ID_LO: fid_n = {fid_q[15:8], cc_byte};
						cctlv_pkg::VAL_SIZE_HI: fsize_n = {cc_byte, 8'h00};
						cctlv_pkg::VAL_SIZE_LO: fsize_n = {fsize_q[15:8], cc_byte};
						cctlv_pkg::VAL_ACCESS: begin
							acc_n = cc_byte;
							verdict_n = cctlv_pkg::ST_FOUND;
							dec_n = 1'b1;
						end
						default: ;
					endcase
					vi_n = vi_q + 3'd1;
				end
				default: ;
			endcase
		end

		if (pos_q == cctlv_pkg::WALK_START - 16'd1)
			phase_n = cctlv_pkg::PH_TYPE;

		pos_n = (pos_q == cctlv_pkg::POS_MAX) ? pos_q : pos_q + 16'd1;

		// too short beats bad length, which beats the walk result
		if (count < {1'b0, cctlv_pkg::MIN_CC_LEN})
			st = cctlv_pkg::ST_SHORT;
		else if (dl_n < cctlv_pkg::MIN_CC_LEN || {1'b0, dl_n} > count)
			st = cctlv_pkg::ST_BADLEN;
		else if (dec_n)
			st = verdict_n;
		else
			st = cctlv_pkg::ST_NOTFOUND;

		result.status = st;
		if (st == cctlv_pkg::ST_FOUND) begin
			result.file_ident = fid_n;
			result.max_file_size = fsize_n;
			result.read_len_max = rl_n;
			result.wr_access = acc_n;
		end else begin
			result.file_ident = '0;
			result.max_file_size = '0;
			result.read_len_max = '0;
			result.wr_access = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			dl_q <= '0;
			rl_q <= '0;
			phase_q <= cctlv_pkg::PH_HEADER;
			type_q <= '0;
			left_q <= '0;
			vi_q <= '0;
			fid_q <= '0;
			fsize_q <= '0;
			acc_q <= '0;
			verdict_q <= cctlv_pkg::ST_NOTFOUND;
			dec_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				// a result returns the parser to its reset state
				pos_q <= '0;
				dl_q <= '0;
				rl_q <= '0;
				phase_q <= cctlv_pkg::PH_HEADER;
				type_q <= '0;
				left_q <= '0;
				vi_q <= '0;
				fid_q <= '0;
				fsize_q <= '0;
				acc_q <= '0;
				verdict_q <= cctlv_pkg::ST_NOTFOUND;
				dec_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				dl_q <= dl_n;
				rl_q <= rl_n;
				phase_q <= phase_n;
				type_q <= type_n;
				left_q <= left_n;
				vi_q <= vi_n;
				fid_q <= fid_n;
				fsize_q <= fsize_n;
				acc_q <= acc_n;
				verdict_q <= verdict_n;
				dec_q <= dec_n;
			end
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for capability_container_tlv_parser_unit: builds containers, predicts
// each result in a parallel parser and compares every result beat; depends on cctlv_pkg
module tb_top;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         hold;	// wait for all pending results before this beat
	} cc_beat_t;

	typedef enum {CC_GOOD, CC_TRUNC, CC_OVERLONG, CC_UNDERLEN, CC_SHORT, CC_NOISE} cc_shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [cctlv_pkg::BYTE_W-1:0] cc_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [cctlv_pkg::STATUS_W-1:0] status;
	logic [cctlv_pkg::WORD_W-1:0] file_ident;
	logic [cctlv_pkg::WORD_W-1:0] max_file_size;
	logic [cctlv_pkg::WORD_W-1:0] read_len_max;
	logic [cctlv_pkg::BYTE_W-1:0] wr_access;

	cc_beat_t beat_queue[$];
	cctlv_pkg::cc_result_t results_due[$];
	int fail_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rx_cycle = 0;

	// parallel parser state
	logic [15:0] p_pos, p_dlen, p_rlim, p_fid, p_fsize;
	logic [7:0] p_type, p_left, p_access;
	logic [2:0] p_vidx;
	cctlv_pkg::walk_phase_t p_phase;
	cctlv_pkg::cc_status_t p_verdict;
	logic p_decided;

	capability_container_tlv_parser_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cc_byte(cc_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.file_ident(file_ident),
		.max_file_size(max_file_size),
		.read_len_max(read_len_max),
		.wr_access(wr_access)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void parser_clear();
		p_pos = '0;
		p_dlen = '0;
		p_rlim = '0;
		p_phase = cctlv_pkg::PH_HEADER;
		p_type = '0;
		p_left = '0;
		p_vidx = '0;
		p_fid = '0;
		p_fsize = '0;
		p_access = '0;
		p_verdict = cctlv_pkg::ST_NOTFOUND;
		p_decided = 1'b0;
	endfunction

	function automatic void decide(cctlv_pkg::cc_status_t st);
		p_verdict = st;
		p_decided = 1'b1;
	endfunction

	function automatic void walk_advance(int unsigned pos, logic [7:0] b);
		int unsigned dl;
		dl = p_dlen;
		if (p_decided || p_phase == cctlv_pkg::PH_HEADER || pos >= dl)
			return;
		case (p_phase)
			cctlv_pkg::PH_TYPE: begin
				// a type byte needs room for its length byte too
				if (pos + 1 < dl && b != 8'h00) begin
					p_type = b;
					p_phase = cctlv_pkg::PH_LENGTH;
				end
			end
			cctlv_pkg::PH_LENGTH: begin
				if (pos + 1 + b > dl)
					decide(cctlv_pkg::ST_OVERRUN);
				else if (p_type == cctlv_pkg::CTRL_TLV_TYPE) begin
					if (b != cctlv_pkg::CTRL_TLV_LEN)
						decide(cctlv_pkg::ST_BADCTRL);
					else begin
						p_vidx = '0;
						p_phase = cctlv_pkg::PH_VALUE;
					end
				end else if (b == 8'h00)
					p_phase = cctlv_pkg::PH_TYPE;
				else begin
					p_left = b;
					p_phase = cctlv_pkg::PH_SKIP;
				end
			end
			cctlv_pkg::PH_SKIP: begin
				p_left = p_left - 8'd1;
				if (p_left == 8'h00)
					p_phase = cctlv_pkg::PH_TYPE;
			end
			cctlv_pkg::PH_VALUE: begin
				case (p_vidx)
					cctlv_pkg::VAL_ID_HI: p_fid = {b, 8'h00};
					cctlv_pkg::VAL_ID_LO: p_fid = p_fid | {8'h00, b};
					cctlv_pkg::VAL_SIZE_HI: p_fsize = {b, 8'h00};
					cctlv_pkg::VAL_SIZE_LO: p_fsize = p_fsize | {8'h00, b};
					cctlv_pkg::VAL_ACCESS: begin
						p_access = b;
						decide(cctlv_pkg::ST_FOUND);
					end
					default: ;
				endcase
				p_vidx = p_vidx + 3'd1;
			end
			default: ;
		endcase
	endfunction

	// advance the parser by one byte; returns 1 with the result on a marked byte
	function automatic bit parse_cc_beat(logic [7:0] b, logic last,
			output cctlv_pkg::cc_result_t r);
		int unsigned pos, count;
		cctlv_pkg::cc_status_t st;
		r = '0;
		pos = p_pos;
		case (p_pos)
			cctlv_pkg::POS_LEN_HI: p_dlen = {b, 8'h00};
			cctlv_pkg::POS_LEN_LO: p_dlen = p_dlen | {8'h00, b};
			cctlv_pkg::POS_READ_HI: p_rlim = {b, 8'h00};
			cctlv_pkg::POS_READ_LO: p_rlim = p_rlim | {8'h00, b};
			default: ;
		endcase
		walk_advance(pos, b);
		if (p_pos == cctlv_pkg::WALK_START - 16'd1)
			p_phase = cctlv_pkg::PH_TYPE;
		if (p_pos != cctlv_pkg::POS_MAX)
			p_pos = p_pos + 16'd1;
		if (!last)
			return 1'b0;
		count = pos + 1;
		if (count < cctlv_pkg::MIN_CC_LEN)
			st = cctlv_pkg::ST_SHORT;
		else if (p_dlen < cctlv_pkg::MIN_CC_LEN || p_dlen > count)
			st = cctlv_pkg::ST_BADLEN;
		else
			st = p_decided ? p_verdict : cctlv_pkg::ST_NOTFOUND;
		r.status = st;
		if (st == cctlv_pkg::ST_FOUND) begin
			r.file_ident = p_fid;
			r.max_file_size = p_fsize;
			r.read_len_max = p_rlim;
			r.wr_access = p_access;
		end
		parser_clear();
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_tlv(ref byte_q_t w, input logic [7:0] t, input logic [7:0] len,
			input int body);
		w.insert(w.size(), t);
		w.insert(w.size(), len);
		repeat (body) w.insert(w.size(), 8'($urandom));
	endfunction

	function automatic void add_ctrl(ref byte_q_t w, input logic [7:0] len, input logic [15:0] fid,
			input logic [15:0] fsize, input logic [7:0] wr);
		w.insert(w.size(), cctlv_pkg::CTRL_TLV_TYPE);
		w.insert(w.size(), len);
		w.insert(w.size(), fid[15:8]);
		w.insert(w.size(), fid[7:0]);
		w.insert(w.size(), fsize[15:8]);
		w.insert(w.size(), fsize[7:0]);
		w.insert(w.size(), 8'($urandom));
		w.insert(w.size(), wr);
	endfunction

	// padding, a skipped tlv, or now and then one that runs past the container
	function automatic void add_filler(ref byte_q_t w);
		logic [7:0] t;
		int len;
		t = 8'($urandom_range(1, 255));
		if (t == cctlv_pkg::CTRL_TLV_TYPE)
			t = ~t;
		case ($urandom_range(0, 39))
			0: add_tlv(w, t, 8'($urandom_range(40, 255)), $urandom_range(0, 4));
			1: begin
				len = $urandom_range(200, 255);
				add_tlv(w, t, 8'(len), len);
			end
			2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19:
				repeat ($urandom_range(1, 3)) w.insert(w.size(), 8'h00);
			default: begin
				len = $urandom_range(0, 8);
				add_tlv(w, t, 8'(len), len);
			end
		endcase
	endfunction

	function automatic void queue_beats(byte_q_t q, bit hold);
		foreach (q[i])
			beat_queue.insert(beat_queue.size(),
				cc_beat_t'{q[i], i == q.size() - 1, hold && i == 0});
	endfunction

	function automatic void send_cc(logic [15:0] dl, logic [15:0] rsize, byte_q_t walk, int tail,
			bit hold);
		byte_q_t q;
		q.insert(q.size(), dl[15:8]);
		q.insert(q.size(), dl[7:0]);
		q.insert(q.size(), 8'($urandom));
		q.insert(q.size(), rsize[15:8]);
		q.insert(q.size(), rsize[7:0]);
		q.insert(q.size(), 8'($urandom));
		q.insert(q.size(), 8'($urandom));
		foreach (walk[i]) q.insert(q.size(), walk[i]);
		repeat (tail) q.insert(q.size(), 8'($urandom));
		queue_beats(q, hold);
	endfunction

	function automatic void send_random_cc(bit hold);
		byte_q_t w;
		cc_shape_t shape;
		int pick, count, tail;
		logic [15:0] dl;
		pick = $urandom_range(0, 99);
		if (pick < 60) shape = CC_GOOD;
		else if (pick < 70) shape = CC_TRUNC;
		else if (pick < 78) shape = CC_OVERLONG;
		else if (pick < 84) shape = CC_UNDERLEN;
		else if (pick < 90) shape = CC_SHORT;
		else shape = CC_NOISE;
		if (shape == CC_SHORT) begin
			repeat ($urandom_range(1, 14)) w.insert(w.size(), 8'($urandom));
			queue_beats(w, hold);
			return;
		end
		if (shape == CC_NOISE)
			repeat ($urandom_range(8, 40)) w.insert(w.size(), 8'($urandom));
		else begin
			repeat ($urandom_range(0, 3)) add_filler(w);
			pick = $urandom_range(0, 9);
			if (pick < 8)
				add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, pick16(), pick16(), 8'(pick16()));
			else if (pick == 8)
				add_ctrl(w, 8'($urandom), pick16(), pick16(), 8'(pick16()));
			repeat ($urandom_range(0, 2)) add_filler(w);
			while (w.size() < 8) w.insert(w.size(), 8'h00);
		end
		count = 7 + w.size();
		case (shape)
			CC_TRUNC: dl = 16'(count - $urandom_range(0, count - 15));
			CC_OVERLONG: dl = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
				16'(count + $urandom_range(1, 300));
			CC_UNDERLEN: dl = 16'($urandom_range(0, 14));
			default: dl = 16'(count);
		endcase
		tail = (shape == CC_GOOD && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		send_cc(dl, pick16(), w, tail, hold);
	endfunction

	// sender: bursts of beats separated by random gaps
	always @(posedge clk) begin : drive_bytes
		cctlv_pkg::cc_result_t res;
		logic next_valid;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (parse_cc_beat(cc_byte, last_byte, res))
					results_due.insert(results_due.size(), res);
				void'(beat_queue.pop_front());
				next_valid = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (beat_queue.size() > 0 &&
						!(beat_queue[0].hold && results_due.size() > 0)) begin
					next_valid = 1'b1;
					cc_byte <= beat_queue[0].data;
					last_byte <= beat_queue[0].last;
				end
			end
		end
		in_valid <= next_valid;
	end

	// receiver: cycles through full rate, random, periodic and heavy stall patterns
	always @(posedge clk) begin : drive_ready
		int mode;
		rx_cycle++;
		mode = (rx_cycle / 300) % 4;
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= (rx_cycle % 11) < 4;
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		cctlv_pkg::cc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing pending, status %0d", status);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("file_ident", want.file_ident, file_ident);
				check_field("max_file_size", want.max_file_size, max_file_size);
				check_field("read_len_max", want.read_len_max, read_len_max);
				check_field("wr_access", 16'(want.wr_access), 16'(wr_access));
			end
		end
	end

	initial begin
		byte_q_t w;
		parser_clear();

		// smallest well-formed containers, field extremes
		add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, 16'hE104, 16'h0800, 8'h00);
		send_cc(16'd15, 16'h00FF, w, 0, 1'b0);
		w.delete();
		add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_cc(16'd15, 16'hFFFF, w, 0, 1'b0);
		w.delete();
		add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, 16'h0000, 16'h0000, 8'h00);
		send_cc(16'd15, 16'h0000, w, 0, 1'b0);
		// too short: one byte, then fourteen
		w.delete();
		w.insert(w.size(), 8'hFF);
		queue_beats(w, 1'b0);
		w.delete();
		repeat (14) w.insert(w.size(), 8'($urandom));
		queue_beats(w, 1'b0);
		// declared length beyond the byte count, zero, and just under the minimum
		w.delete();
		add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, 16'h1234, 16'h5678, 8'h00);
		send_cc(16'd16, 16'h0040, w, 0, 1'b0);
		send_cc(16'd0, 16'h0040, w, 0, 1'b0);
		send_cc(16'd14, 16'h0040, w, 0, 1'b0);
		// control tlv with the wrong length
		w.delete();
		add_ctrl(w, 8'd5, 16'h1234, 16'h5678, 8'h00);
		send_cc(16'd15, 16'h0040, w, 0, 1'b0);
		// skipped tlv whose length runs past the container
		w.delete();
		add_tlv(w, 8'h10, 8'hFF, 6);
		send_cc(16'd15, 16'h0040, w, 0, 1'b0);
		// only padding, then a type byte in the final position
		w.delete();
		repeat (8) w.insert(w.size(), 8'h00);
		send_cc(16'd15, 16'h0040, w, 0, 1'b0);
		w.delete();
		repeat (7) w.insert(w.size(), 8'h00);
		w.insert(w.size(), cctlv_pkg::CTRL_TLV_TYPE);
		send_cc(16'd15, 16'h0040, w, 0, 1'b0);
		// padding, empty and short unknown tlvs, control tlv, a bad one after the decision,
		// bytes past the declared length
		w.delete();
		w.insert(w.size(), 8'h00);
		w.insert(w.size(), 8'h00);
		add_tlv(w, 8'h03, 8'h00, 0);
		add_tlv(w, 8'hFD, 8'h03, 3);
		add_ctrl(w, cctlv_pkg::CTRL_TLV_LEN, 16'hA55A, 16'h7FFE, 8'h80);
		add_tlv(w, cctlv_pkg::CTRL_TLV_TYPE, 8'h01, 1);
		send_cc(16'(7 + w.size()), 16'hFFFE, w, 3, 1'b0);

		send_random_cc(1'b1);
		while (beat_queue.size() < 1500)
			send_random_cc($urandom_range(0, 9) == 0);

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (beat_queue.size() > 0 || in_valid || results_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
